FILE: rtl/buddy_page_allocator_defines.svh
// assertion macros shared by the checker files
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BPA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bpa_pkg.sv
// shared constants, types and helper functions of the buddy page allocator
`default_nettype none
package bpa_pkg;
	localparam int CLASS_NUM  = 12;
	localparam int POOL_PAGES = 65536;
	localparam int PAGE_W     = $clog2(POOL_PAGES);
	localparam int CNT_W      = PAGE_W + 1;
	localparam int LINK_W     = PAGE_W + 1;
	localparam int CLS_W      = $clog2(CLASS_NUM);
	localparam int NEED_W     = $clog2(CNT_W + 1);
	localparam logic [CNT_W-1:0] TOTAL_MAX = '1;
	localparam logic [CLS_W-1:0] CLS_TOP   = CLS_W'(CLASS_NUM - 1);
	localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(POOL_PAGES);

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ZERO   = 2'd1;
	localparam logic [1:0] ST_NOBLK  = 2'd2;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [3:0] {
		CMD_NOP, CMD_CLR, CMD_LOAD, CMD_A_CHK, CMD_POP_RD, CMD_POP_WR,
		CMD_SKIP, CMD_PUSH1, CMD_PUSH2, CMD_F_START, CMD_TGL_RD,
		CMD_TGL_WR, CMD_UNLINK, CMD_OUT
	} cmd_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_A_CHK, S_POP_RD, S_POP_WR, S_A_STEP, S_PUSH1,
		S_PUSH2, S_F_START, S_F_TRD, S_F_TDEC, S_F_UNL, S_FIN
	} state_t;

	typedef struct packed {
		logic clr_last;
		logic cnt_zero;
		logic no_blk;
		logic i_zero;
		logic rem_gt_half;
		logic rem_eq_half;
		logic k_done;
		logic cls_top;
		logic bf;
		logic out_busy;
		logic is_free;
	} dp_stat_t;

	// toggle bit of the buddy pair holding pg at class c, classes packed in turn
	function automatic logic [PAGE_W-1:0] tgl_idx(input logic [PAGE_W-1:0] pg,
			input logic [CLS_W-1:0] c);
		logic [PAGE_W:0] pool;
		logic [PAGE_W:0] base;
		logic [PAGE_W-1:0] sh;
		pool = (PAGE_W+1)'(POOL_PAGES);
		base = pool - (pool >> c);
		sh   = pg >> ({1'b0, c} + (CLS_W+1)'(1));
		return base[PAGE_W-1:0] + sh;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/buddy_page_allocator.sv
// top level of the buddy page allocator: sequencer plus datapath
//
// channel  dir  tdata (low bit up)                     tuser
// s_axis   in   first_page[15:0] page_count[32:16]     func (0 alloc, 1 free)
// m_axis   out  alloc_page[15:0] pages_free[32:16]     status (0 ok, 1 zero, 2 none)
//
// sequence, from the accepting edge to the result word: allocate goes straight to
//   the result on a zero count or when no block fits, else pops the smallest usable
//   block and splits it class by class, keeping the halves it needs and pushing the
//   rest onto the free lists; free works page by page, merging with free buddies
// reset: after arst_n the toggle ram is cleared, one entry a cycle, across all
//   65536 entries; s_tready stays low until that pass is done
// stalls: one word is taken at a time; a finished word waits in the output
//   register while the next word is taken and worked on
`default_nettype none
module buddy_page_allocator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // first_page, page_count, zero fill
	input  wire logic        s_tuser,   // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,   // alloc_page, pages_free, zero fill
	output logic      [1:0]  m_tuser    // status
);
	import bpa_pkg::*;

	cmd_t              cmd;
	dp_stat_t          stat;
	logic [PAGE_W-1:0] out_page;
	logic [CNT_W-1:0]  out_free;

	// control: one state machine walks classes and pages
	bpa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_func(s_tuser),
		.stat(stat), .in_ready(s_tready), .cmd(cmd)
	);

	// datapath: heads, rams, counters and the output register
	bpa_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_func(s_tuser),
		.in_first(s_tdata[PAGE_W-1:0]),
		.in_count(s_tdata[PAGE_W+CNT_W-1:PAGE_W]),
		.stat(stat),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_page(out_page), .out_status(m_tuser), .out_free(out_free)
	);

	// pack result word, upper seven bits of fill are zero
	assign m_tdata = {{(40-PAGE_W-CNT_W){1'b0}}, out_free, out_page};
endmodule
`default_nettype wire

FILE: rtl/bpa_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/bpa_ctrl.sv
// sequencer of the buddy page allocator
`default_nettype none
module bpa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_func,
	input  wire bpa_pkg::dp_stat_t stat,
	output logic                   in_ready,
	output bpa_pkg::cmd_t          cmd
);
	import bpa_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_CLR:     if (stat.clr_last) state_nx = S_IDLE;
			S_IDLE:    if (in_valid) state_nx = (in_func == FUNC_FREE) ? S_F_START : S_A_CHK;
			S_A_CHK:   state_nx = (stat.cnt_zero || stat.no_blk) ? S_FIN : S_POP_RD;
			S_POP_RD:  state_nx = S_POP_WR;
			S_POP_WR:  state_nx = S_A_STEP;
			S_A_STEP: begin
				if (stat.i_zero) state_nx = S_FIN;
				else if (!stat.rem_gt_half) state_nx = S_PUSH1;
			end
			S_PUSH1:   state_nx = S_PUSH2;
			S_PUSH2: begin
				if (stat.is_free) state_nx = S_F_START;
				else state_nx = stat.rem_eq_half ? S_FIN : S_A_STEP;
			end
			S_F_START: state_nx = stat.k_done ? S_FIN : S_F_TRD;
			S_F_TRD:   state_nx = stat.cls_top ? S_PUSH1 : S_F_TDEC;
			S_F_TDEC:  state_nx = stat.bf ? S_F_UNL : S_PUSH1;
			S_F_UNL:   state_nx = S_F_TRD;
			S_FIN:     if (!stat.out_busy) state_nx = S_IDLE;
			default:   state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = CMD_NOP;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLR:     cmd = CMD_CLR;
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd = CMD_LOAD;
			end
			S_A_CHK:   cmd = CMD_A_CHK;
			S_POP_RD:  cmd = CMD_POP_RD;
			S_POP_WR:  cmd = CMD_POP_WR;
			S_A_STEP:  if (!stat.i_zero && stat.rem_gt_half) cmd = CMD_SKIP;
			S_PUSH1:   cmd = CMD_PUSH1;
			S_PUSH2:   cmd = CMD_PUSH2;
			S_F_START: if (!stat.k_done) cmd = CMD_F_START;
			S_F_TRD:   if (!stat.cls_top) cmd = CMD_TGL_RD;
			S_F_TDEC:  cmd = CMD_TGL_WR;
			S_F_UNL:   cmd = CMD_UNLINK;
			S_FIN:     if (!stat.out_busy) cmd = CMD_OUT;
			default:   cmd = CMD_NOP;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/bpa_dp.sv
// datapath: list heads, link and toggle rams, counters and result register
`default_nettype none
module bpa_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bpa_pkg::cmd_t               cmd,
	input  wire logic                        in_func,
	input  wire logic [bpa_pkg::PAGE_W-1:0]  in_first,
	input  wire logic [bpa_pkg::CNT_W-1:0]   in_count,
	output bpa_pkg::dp_stat_t                stat,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [bpa_pkg::PAGE_W-1:0]  out_page,
	output logic      [1:0]                  out_status,
	output logic      [bpa_pkg::CNT_W-1:0]   out_free
);
	import bpa_pkg::*;

	logic [LINK_W-1:0] heads_q [CLASS_NUM];
	logic [CNT_W-1:0]  total_q;
	logic [PAGE_W-1:0] clr_q;
	logic              func_q;
	logic [PAGE_W-1:0] first_q, page_q, begin_q, pp_q;
	logic [CNT_W-1:0]  count_q, k_q, rem_q;
	logic [CLS_W-1:0]  i_q, cls_q;
	logic [LINK_W-1:0] oldhead_q;
	logic [1:0]        status_q;

	logic [CLS_W-1:0]  im1, hidx, fcls;
	logic [CNT_W-1:0]  half, cm1, sub_tot;
	logic [CNT_W:0]    sum;
	logic [CNT_W-1:0]  add_tot;
	logic [NEED_W-1:0] need;
	logic              found;
	logic [PAGE_W-1:0] bud, pp;
	logic [LINK_W-1:0] hsel;

	logic              nx_we, pv_we, tg_we;
	logic [PAGE_W-1:0] nx_wa, pv_wa, tg_wa, nx_ra, tg_ra;
	logic [LINK_W-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
	logic              tg_wd, tg_rd;

	assign im1  = i_q - CLS_W'(1);
	assign half = CNT_W'(1) << im1;
	assign cm1  = count_q - CNT_W'(1);
	assign bud  = page_q ^ (PAGE_W'(1) << cls_q);
	assign pp   = func_q ? page_q : page_q + half[PAGE_W-1:0];
	assign hidx = (cmd == CMD_PUSH1 && !func_q) ? im1 : cls_q;
	assign hsel = heads_q[hidx];
	assign sub_tot = (total_q > count_q) ? total_q - count_q : '0;
	assign sum     = {1'b0, total_q} + {1'b0, count_q};
	assign add_tot = sum[CNT_W] ? TOTAL_MAX : sum[CNT_W-1:0];

	// class ceiling of the request, then the smallest usable non-empty class
	always_comb begin
		need  = '0;
		found = 1'b0;
		fcls  = '0;
		for (int b = 0; b < CNT_W; b++) begin
			if (cm1[b]) need = NEED_W'(b + 1);
		end
		for (int c = CLASS_NUM - 1; c >= 0; c--) begin
			if (NEED_W'(c) >= need && !heads_q[c][PAGE_W]) begin
				found = 1'b1;
				fcls  = CLS_W'(c);
			end
		end
	end

	always_comb begin
		stat.clr_last    = &clr_q;
		stat.cnt_zero    = (count_q == '0);
		stat.no_blk      = !found;
		stat.i_zero      = (i_q == '0);
		stat.rem_gt_half = (rem_q > half);
		stat.rem_eq_half = (rem_q == half);
		stat.k_done      = (k_q == count_q);
		stat.cls_top     = (cls_q == CLS_TOP);
		stat.bf          = tg_rd;
		stat.out_busy    = out_valid;
		stat.is_free     = func_q;
	end

	// ram port selection
	always_comb begin
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
		pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
		tg_we = 1'b0; tg_wa = '0; tg_wd = 1'b0;
		nx_ra = (cmd == CMD_POP_RD) ? heads_q[cls_q][PAGE_W-1:0] : bud;
		tg_ra = tgl_idx(page_q, cls_q);
		unique case (cmd)
			CMD_CLR: begin
				tg_we = 1'b1; tg_wa = clr_q;
			end
			CMD_POP_WR: begin
				pv_we = !nx_rd[PAGE_W]; pv_wa = nx_rd[PAGE_W-1:0]; pv_wd = LINK_NIL;
				tg_we = (cls_q != CLS_TOP); tg_wa = tgl_idx(page_q, cls_q);
			end
			CMD_PUSH1: begin
				nx_we = 1'b1; nx_wa = pp; nx_wd = hsel;
				pv_we = 1'b1; pv_wa = pp; pv_wd = LINK_NIL;
				tg_we = !func_q; tg_wa = tgl_idx(page_q, im1); tg_wd = 1'b1;
			end
			CMD_PUSH2: begin
				pv_we = !oldhead_q[PAGE_W]; pv_wa = oldhead_q[PAGE_W-1:0];
				pv_wd = {1'b0, pp_q};
			end
			CMD_TGL_WR: begin
				tg_we = 1'b1; tg_wa = tgl_idx(page_q, cls_q); tg_wd = !tg_rd;
			end
			CMD_UNLINK: begin
				pv_we = !nx_rd[PAGE_W]; pv_wa = nx_rd[PAGE_W-1:0]; pv_wd = pv_rd;
				nx_we = !pv_rd[PAGE_W]; nx_wa = pv_rd[PAGE_W-1:0]; nx_wd = nx_rd;
			end
			default: ;
		endcase
	end

	bpa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_PAGES)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd)
	);
	bpa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_PAGES)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(bud), .rdata(pv_rd)
	);
	bpa_ram #(.WIDTH(1), .DEPTH(POOL_PAGES)) u_tgl (
		.clk(clk), .we(tg_we), .waddr(tg_wa), .wdata(tg_wd), .raddr(tg_ra), .rdata(tg_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CLASS_NUM; c++) heads_q[c] <= LINK_NIL;
			total_q   <= '0;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (cmd)
				CMD_CLR:    clr_q <= clr_q + PAGE_W'(1);
				CMD_POP_WR: begin
					heads_q[cls_q] <= nx_rd;
					total_q        <= sub_tot;
				end
				CMD_PUSH1:  heads_q[hidx] <= {1'b0, pp};
				CMD_UNLINK: begin
					if (pv_rd[PAGE_W] && heads_q[cls_q] == {1'b0, bud}) heads_q[cls_q] <= nx_rd;
				end
				CMD_OUT: begin
					out_valid <= 1'b1;
					if (func_q) total_q <= add_tot;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_LOAD: begin
				func_q   <= in_func;
				first_q  <= in_first;
				count_q  <= in_count;
				k_q      <= '0;
				status_q <= ST_OK;
			end
			CMD_A_CHK: begin
				cls_q <= fcls;
				if (count_q == '0) status_q <= ST_ZERO;
				else if (!found) status_q <= ST_NOBLK;
			end
			CMD_POP_RD: begin
				page_q  <= heads_q[cls_q][PAGE_W-1:0];
				begin_q <= heads_q[cls_q][PAGE_W-1:0];
			end
			CMD_POP_WR: begin
				rem_q <= count_q;
				i_q   <= cls_q;
			end
			CMD_SKIP: begin
				rem_q  <= rem_q - half;
				page_q <= page_q + half[PAGE_W-1:0];
				i_q    <= im1;
			end
			CMD_PUSH1: begin
				oldhead_q <= hsel;
				pp_q      <= pp;
			end
			CMD_PUSH2: begin
				if (func_q) k_q <= k_q + CNT_W'(1);
				else i_q <= im1;
			end
			CMD_F_START: begin
				page_q <= first_q + k_q[PAGE_W-1:0];
				cls_q  <= '0;
			end
			CMD_UNLINK: begin
				if (bud < page_q) page_q <= bud;
				cls_q <= cls_q + CLS_W'(1);
			end
			CMD_OUT: begin
				out_page   <= (!func_q && status_q == ST_OK) ? begin_q : '0;
				out_status <= status_q;
				out_free   <= func_q ? add_tot : total_q;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/bpa_checker.sv
// port-level checks of the buddy page allocator and their bind
`default_nettype none
`include "buddy_page_allocator_defines.svh"
module bpa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	import bpa_pkg::*;

	`BPA_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word dropped")
	`BPA_ASSERT_NXT(a_one, s_tvalid && s_tready, !s_tready, "second word taken while busy")
	`BPA_ASSERT_IMP(a_code, m_tvalid, m_tuser <= ST_NOBLK, "bad status code")
	`BPA_ASSERT_IMP(a_errpg, m_tvalid && m_tuser != ST_OK, m_tdata[15:0] == 16'd0, "page on error")
endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
